/* rtl/core/dmlr_pkg.sv */
// ----------------------------------------------------------------------------
// Dashed midpoint line rasteriser package
// Operation codes, register map and stipple constants shared by the block.
// ----------------------------------------------------------------------------
package dmlr_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    localparam int unsigned OP_W = 2;

    // Register map: index of each configuration register.
    localparam logic REG_STIPPLE = 1'b0;

    localparam int unsigned PATTERN_W = 16;
    localparam logic [PATTERN_W-1:0] PATTERN_RESET = 16'h1FFF;

endpackage

/* rtl/core/dashed_midpoint_line_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// Dashed midpoint line rasteriser
// Walks a midpoint line one pixel per tick word and applies a line stipple.
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel: tuser carries the operation
// (tick, load segment, clear stipple phase) and tdata the two endpoints, used
// on a load only. Each tick word while a segment is active yields one pixel
// word on the m_axis channel: tdata holds the coordinates, tuser the stipple
// visibility and tlast marks the final pixel of the segment. Loads, phase
// clears and ticks without a segment produce no word.
// An accepted word is held in the input register and its pixel is then
// computed and written to the output register. A word is accepted every
// cycle unless the receiver stalls; the single add-and-compare step of the
// decision term sets that rate.
// When the receiver stalls, the output register holds its pixel, the input
// register holds at most one further word and s_axis_tready stays low while
// that word waits for the output register.
// The stipple pattern is written over the APB port at address 0.
// Reset clears the walk state, the stipple phase and both registers' valid
// flags, and restores the stipple pattern to its reset value.
// ----------------------------------------------------------------------------
module dashed_midpoint_line_rasterizer_unit #(
    parameter int unsigned COORD_BITS  = 12,
    parameter int unsigned PATTERN_LEN = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input channel.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, lowest bits first: start_x, start_y, end_x, end_y, zero fill.
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // tuser: operation.
    input  logic [dmlr_pkg::OP_W-1:0]              s_axis_tuser,
    // Output channel.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata, lowest bits first: pixel_x, pixel_y, zero fill.
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // tuser: visible.
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast,
    // Configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    import dmlr_pkg::*;

    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned DW    = CB + 4;
    localparam int unsigned SW    = CB + 2;
    localparam int unsigned PH_W  = $clog2(PATTERN_LEN);
    localparam int unsigned IN_W  = ((4*CB+7)/8)*8;
    localparam int unsigned OUT_W = ((2*CB+7)/8)*8;

    // Configuration register.
    logic [PATTERN_W-1:0] r_pattern;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= PATTERN_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_STIPPLE)) begin
            r_pattern <= pwdata[PATTERN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_STIPPLE) ? {{(32-PATTERN_W){1'b0}}, r_pattern} : 32'd0;

    // Input register.
    logic                r_in_valid;
    logic [OP_W-1:0]     r_in_op;
    logic [4*CB-1:0]     r_in_coords;
    logic                adv;

    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op     <= s_axis_tuser;
            r_in_coords <= s_axis_tdata[4*CB-1:0];
        end
    end

    // Segment setup from the held load word.
    logic        [CB-1:0] su_major_pos, su_minor_pos, su_major_end, su_origin;
    logic signed [DW-1:0] su_decision;
    logic signed [SW-1:0] su_step_a, su_step_b;
    logic                 su_mirrored, su_steep;

    dmlr_setup #(
        .COORD_BITS (CB)
    ) u_setup (
        .i_start_x       (r_in_coords[CB-1:0]),
        .i_start_y       (r_in_coords[2*CB-1:CB]),
        .i_end_x         (r_in_coords[3*CB-1:2*CB]),
        .i_end_y         (r_in_coords[4*CB-1:3*CB]),
        .o_major_pos     (su_major_pos),
        .o_minor_pos     (su_minor_pos),
        .o_major_end     (su_major_end),
        .o_mirror_origin (su_origin),
        .o_decision      (su_decision),
        .o_step_a        (su_step_a),
        .o_step_b        (su_step_b),
        .o_mirrored      (su_mirrored),
        .o_steep         (su_steep)
    );

    // Walk state.
    logic        [CB-1:0]   r_major_pos, r_minor_pos, r_major_end, r_origin;
    logic signed [DW-1:0]   r_decision;
    logic signed [SW-1:0]   r_step_a, r_step_b;
    logic                   r_mirrored, r_steep, r_active;
    logic        [PH_W-1:0] r_phase;

    logic        [CB-1:0]   n_major_pos, n_minor_pos, n_major_end, n_origin;
    logic signed [DW-1:0]   n_decision;
    logic signed [SW-1:0]   n_step_a, n_step_b;
    logic                   n_mirrored, n_steep, n_active;
    logic        [PH_W-1:0] n_phase;

    // Output register.
    logic                r_out_valid;
    logic [CB-1:0]       r_px, r_py;
    logic                r_vis, r_last;

    logic                produce;
    logic [CB-1:0]       px, py, py_raw;
    logic                vis, last;
    logic [PATTERN_W-1:0] pat_shift;

    always_comb begin
        n_major_pos = r_major_pos;
        n_minor_pos = r_minor_pos;
        n_major_end = r_major_end;
        n_origin    = r_origin;
        n_decision  = r_decision;
        n_step_a    = r_step_a;
        n_step_b    = r_step_b;
        n_mirrored  = r_mirrored;
        n_steep     = r_steep;
        n_active    = r_active;
        n_phase     = r_phase;
        produce     = 1'b0;

        if (r_steep) begin
            px     = r_minor_pos;
            py_raw = r_major_pos;
        end else begin
            px     = r_major_pos;
            py_raw = r_minor_pos;
        end
        // A falling line was walked rising; reflect it back about the start row.
        if (r_mirrored) begin
            py = {r_origin[CB-2:0], 1'b0} - py_raw;
        end else begin
            py = py_raw;
        end

        last = (r_major_pos == r_major_end);
        if (r_phase == PH_W'(PATTERN_LEN - 1)) begin
            pat_shift = r_pattern;
            vis       = r_pattern[0];
        end else begin
            pat_shift = r_pattern >> (r_phase + 1'b1);
            vis       = pat_shift[0];
        end

        case (t_op'(r_in_op))
            OP_LOAD: begin
                n_major_pos = su_major_pos;
                n_minor_pos = su_minor_pos;
                n_major_end = su_major_end;
                n_origin    = su_origin;
                n_decision  = su_decision;
                n_step_a    = su_step_a;
                n_step_b    = su_step_b;
                n_mirrored  = su_mirrored;
                n_steep     = su_steep;
                n_active    = 1'b1;
            end
            OP_CLEAR: begin
                n_phase = '0;
            end
            OP_TICK: begin
                if (r_active) begin
                    produce = 1'b1;
                    if (r_phase == PH_W'(PATTERN_LEN - 1)) begin
                        n_phase = '0;
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                    if (last) begin
                        n_active = 1'b0;
                    end else begin
                        n_major_pos = r_major_pos + 1'b1;
                        if (r_decision > 0) begin
                            n_minor_pos = r_minor_pos + 1'b1;
                            n_decision  = r_decision + {{(DW-SW){r_step_b[SW-1]}}, r_step_b};
                        end else begin
                            n_decision  = r_decision + {{(DW-SW){r_step_a[SW-1]}}, r_step_a};
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // A held word that yields no pixel never waits for the output register.
    assign adv = r_in_valid && (!produce || !r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_pos <= '0;
            r_minor_pos <= '0;
            r_major_end <= '0;
            r_origin    <= '0;
            r_decision  <= '0;
            r_step_a    <= '0;
            r_step_b    <= '0;
            r_mirrored  <= 1'b0;
            r_steep     <= 1'b0;
            r_active    <= 1'b0;
            r_phase     <= '0;
        end else if (adv) begin
            r_major_pos <= n_major_pos;
            r_minor_pos <= n_minor_pos;
            r_major_end <= n_major_end;
            r_origin    <= n_origin;
            r_decision  <= n_decision;
            r_step_a    <= n_step_a;
            r_step_b    <= n_step_b;
            r_mirrored  <= n_mirrored;
            r_steep     <= n_steep;
            r_active    <= n_active;
            r_phase     <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && produce) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && produce) begin
            r_px   <= px;
            r_py   <= py;
            r_vis  <= vis;
            r_last <= last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_py, r_px});
    assign m_axis_tuser  = r_vis;
    assign m_axis_tlast  = r_last;

    // Padding bits of the input word, the upper pwdata bits and paddr[1:0] carry nothing.
    logic unused_pad;
    assign unused_pad = ^(s_axis_tdata >> (4*CB)) ^ ^pwdata[31:PATTERN_W] ^ ^paddr[1:0];

endmodule

/* rtl/core/dmlr_setup.sv */
// ----------------------------------------------------------------------------
// Segment setup
// Orders the endpoints by x, folds the line into the first octant and derives
// the start position, end position and decision terms of the midpoint walk.
// ----------------------------------------------------------------------------
module dmlr_setup #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic        [COORD_BITS-1:0] o_major_pos,
    output logic        [COORD_BITS-1:0] o_minor_pos,
    output logic        [COORD_BITS-1:0] o_major_end,
    output logic        [COORD_BITS-1:0] o_mirror_origin,
    output logic signed [COORD_BITS+3:0] o_decision,
    output logic signed [COORD_BITS+1:0] o_step_a,
    output logic signed [COORD_BITS+1:0] o_step_b,
    output logic                         o_mirrored,
    output logic                         o_steep
);

    localparam int unsigned CB = COORD_BITS;

    logic signed [CB-1:0] ax, ay, bx, by;
    logic        [CB:0]   dx_full, dy_full;
    logic        [CB-1:0] dx, dy, dmaj, dmin;
    logic        [CB:0]   dstep;

    always_comb begin
        if (i_start_x > i_end_x) begin
            ax = i_end_x;
            ay = i_end_y;
            bx = i_start_x;
            by = i_start_y;
        end else begin
            ax = i_start_x;
            ay = i_start_y;
            bx = i_end_x;
            by = i_end_y;
        end

        o_mirrored = (ay > by);
        dx_full = {bx[CB-1], bx} - {ax[CB-1], ax};
        if (o_mirrored) begin
            dy_full = {ay[CB-1], ay} - {by[CB-1], by};
        end else begin
            dy_full = {by[CB-1], by} - {ay[CB-1], ay};
        end
        // Both differences are non-negative and below 2^COORD_BITS.
        dx = dx_full[CB-1:0];
        dy = dy_full[CB-1:0];

        o_steep = (dy > dx);
        o_mirror_origin = ay;
        if (o_steep) begin
            o_major_pos = ay;
            o_minor_pos = ax;
            o_major_end = ay + dy;
            dmaj        = dy;
            dmin        = dx;
        end else begin
            o_major_pos = ax;
            o_minor_pos = ay;
            o_major_end = bx;
            dmaj        = dx;
            dmin        = dy;
        end

        o_decision = {3'b000, dmin, 1'b0} - {4'b0000, dmaj};
        o_step_a   = {1'b0, dmin, 1'b0};
        dstep      = {1'b0, dmin} - {1'b0, dmaj};
        o_step_b   = {dstep, 1'b0};
    end

endmodule

/* tb/sv/dmlr_pixel_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel checker for the dashed midpoint line rasteriser
// Watches the input, output and APB channels and keeps its own copy of the
// line walk and stipple state. Every accepted tick word that finds a segment
// loaded queues the expected pixel. Every pixel word taken by the receiver is
// compared with the oldest expected pixel. Register reads are compared with
// the last pattern written.
// ----------------------------------------------------------------------------
module dmlr_pixel_checker #(
    parameter int unsigned CW = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    // tdata, lowest bits first: start_x, start_y, end_x, end_y.
    input  logic [4*CW-1:0]           s_axis_tdata,
    // tuser: operation.
    input  logic [dmlr_pkg::OP_W-1:0] s_axis_tuser,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata, lowest bits first: pixel_x, pixel_y.
    input  logic [2*CW-1:0]           m_axis_tdata,
    // tuser: visible.
    input  logic                      m_axis_tuser,
    input  logic                      m_axis_tlast,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [31:0]               pwdata,
    input  logic [31:0]               prdata,
    input  logic                      pready,
    output int                        o_mismatches,
    output int                        o_pixels_pending
);

    import dmlr_pkg::*;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          vis;
        logic          last;
    } t_pixel;

    t_pixel pixel_q[$];
    int     errors = 0;

    // Walk state, kept in the block's own frame (after mirror and swap).
    logic [CW-1:0]        major_at, minor_at, major_stop, mirror_row;
    logic signed [15:0]   err_term;
    logic signed [13:0]   inc_straight, inc_diag;
    logic                 mirrored, steep_walk, walking;
    logic [3:0]           dash_phase;
    logic [PATTERN_W-1:0] dash_mask;

    function automatic string show_pixel(input t_pixel p);
        return $sformatf("x=%0d y=%0d visible=%b last=%b",
                         $signed(p.x), $signed(p.y), p.vis, p.last);
    endfunction

    task automatic load_walk(input logic [4*CW-1:0] ends);
        int sx, sy, ex, ey, t, dx, dy, dmaj, dmin;
        sx = $signed(ends[CW-1:0]);
        sy = $signed(ends[2*CW-1:CW]);
        ex = $signed(ends[3*CW-1:2*CW]);
        ey = $signed(ends[4*CW-1:3*CW]);
        if (sx > ex) begin
            t = sx; sx = ex; ex = t;
            t = sy; sy = ey; ey = t;
        end
        mirrored   = sy > ey;
        dx         = ex - sx;
        dy         = mirrored ? sy - ey : ey - sy;
        steep_walk = dy > dx;
        mirror_row = CW'(sy);
        if (steep_walk) begin
            major_at   = CW'(sy);
            minor_at   = CW'(sx);
            major_stop = CW'(sy + dy);
            dmaj       = dy;
            dmin       = dx;
        end else begin
            major_at   = CW'(sx);
            minor_at   = CW'(sy);
            major_stop = CW'(ex);
            dmaj       = dx;
            dmin       = dy;
        end
        err_term     = 16'(2 * dmin - dmaj);
        inc_straight = 14'(2 * dmin);
        inc_diag     = 14'(2 * (dmin - dmaj));
        walking      = 1'b1;
    endtask

    task automatic step_walk();
        t_pixel        p;
        logic [CW-1:0] y;
        if (!walking)
            return;
        p.x = steep_walk ? minor_at : major_at;
        y   = steep_walk ? major_at : minor_at;
        // A falling line was walked as a rising one; reflect it back.
        if (mirrored)
            y = CW'(2 * mirror_row - y);
        p.y = y;
        // The phase moves on before the pixel, so the first after a clear is 1.
        dash_phase = dash_phase + 4'd1;
        p.vis      = dash_mask[dash_phase];
        p.last     = (major_at == major_stop);
        if (p.last) begin
            walking = 1'b0;
        end else begin
            major_at = major_at + 1'b1;
            if (err_term > 0) begin
                minor_at = minor_at + 1'b1;
                err_term = err_term + inc_diag;
            end else begin
                err_term = err_term + inc_straight;
            end
        end
        pixel_q.insert(pixel_q.size(), p);
    endtask

    always @(posedge i_clk) begin : watch
        t_pixel got, want;
        if (!i_rst_n) begin
            major_at     = '0;
            minor_at     = '0;
            major_stop   = '0;
            mirror_row   = '0;
            err_term     = '0;
            inc_straight = '0;
            inc_diag     = '0;
            mirrored     = 1'b0;
            steep_walk   = 1'b0;
            walking      = 1'b0;
            dash_phase   = '0;
            dash_mask    = PATTERN_RESET;
            pixel_q.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    dash_mask = pwdata[PATTERN_W-1:0];
                end else if (prdata !== 32'(dash_mask)) begin
                    $display("%0t: pattern read mismatch: expected %h, got %h",
                             $time, 32'(dash_mask), prdata);
                    errors++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[CW-1:0], m_axis_tdata[2*CW-1:CW],
                       m_axis_tuser, m_axis_tlast};
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected pixel: expected none, got %s",
                             $time, show_pixel(got));
                    errors++;
                end else begin
                    want = pixel_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: pixel mismatch: expected %s, got %s",
                                 $time, show_pixel(want), show_pixel(got));
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    OP_LOAD:  load_walk(s_axis_tdata);
                    OP_CLEAR: dash_phase = '0;
                    OP_TICK:  step_walk();
                    default:  ;
                endcase
            end
        end
        o_pixels_pending <= pixel_q.size();
        o_mismatches     <= errors;
    end

endmodule

/* tb/sv/tb_dashed_midpoint_line_rasterizer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the dashed midpoint line rasteriser
// Drives load, tick, phase clear and unused-operation words with random
// gaps, stalls the pixel receiver at random and once for a long stretch, and
// rewrites the stipple pattern between phases. A checker beside the block
// predicts and compares every pixel word.
// ----------------------------------------------------------------------------
module tb_dashed_midpoint_line_rasterizer_unit;
    import dmlr_pkg::*;

    localparam int unsigned CW          = 12;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          LIMIT       = 400000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN       = 6;
    localparam int          SEG_WORDS   = 150;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [4*CW-1:0]   s_axis_tdata  = '0;
    logic [OP_W-1:0]   s_axis_tuser  = OP_TICK;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [2*CW-1:0]   m_axis_tdata;
    logic              m_axis_tuser;
    logic              m_axis_tlast;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [2:0]        paddr         = '0;
    logic [31:0]       pwdata        = '0;
    logic [31:0]       prdata;
    logic              pready;

    int mismatches;
    int pixels_pending;
    int words_sent   = 0;
    int cycle_count  = 0;
    int idle_on      = 1;
    int hold_request = 0;

    dashed_midpoint_line_rasterizer_unit #(
        .COORD_BITS  (CW),
        .PATTERN_LEN (16)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dmlr_pixel_checker #(
        .CW (CW)
    ) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .m_axis_tlast     (m_axis_tlast),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_mismatches     (mismatches),
        .o_pixels_pending (pixels_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("tb_dashed_midpoint_line_rasterizer_unit failed");
            $finish;
        end
    end

    // Pixel receiver: a random stall before each word, or one long hold-off
    // on request so that the block backs up into its input.
    initial begin : pixel_sink
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request != 0 && !hold_done) begin
                hold_done = 1'b1;
                stall = HOLD_CYCLES;
            end else begin
                stall = idle_on ? $urandom_range(0, 5) : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_word(input logic [1:0] op, input int sx, input int sy,
                             input int ex, input int ey);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {CW'(ey), CW'(ex), CW'(sy), CW'(sx)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic apb_access(input logic write, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= 3'(4 * REG_STIPPLE);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every expected pixel has come out, then lets any word that
    // makes no pixel leave the pipeline.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pixels_pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic int offset(input int base, input int reach);
        int d;
        d = $urandom_range(0, reach);
        if ($urandom_range(0, 1) != 0)
            d = -d;
        if (base + d > 2047 || base + d < -2048)
            d = -d;
        return base + d;
    endfunction

    task automatic random_segments(input int count);
        int first, sx, sy, ex, ey, reach, len, ticks;
        first = words_sent;
        while (words_sent - first < count) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                send_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
                continue;
            end
            reach = ($urandom_range(0, 7) == 0) ? 60 : 10;
            sx    = int'($urandom_range(0, 4095)) - 2048;
            sy    = int'($urandom_range(0, 4095)) - 2048;
            ex    = offset(sx, reach);
            ey    = offset(sy, reach);
            len   = ((ex > sx ? ex - sx : sx - ex) > (ey > sy ? ey - sy : sy - ey) ?
                     (ex > sx ? ex - sx : sx - ex) : (ey > sy ? ey - sy : sy - ey)) + 1;
            case ($urandom_range(0, 7))
                0:       ticks = $urandom_range(0, len - 1);    // cut short by the next load
                1:       ticks = len + $urandom_range(1, 3);    // spare ticks find no segment
                default: ticks = len;
            endcase
            send_word(OP_LOAD, sx, sy, ex, ey);
            for (int i = 0; i < ticks; i++) begin
                if ($urandom_range(0, 29) == 0)
                    send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
                send_word(OP_TICK, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin : stimulus
        logic [31:0] patterns[6];
        patterns = '{32'h0000, 32'hFFFF, 32'hAAAA, 32'h0001, 32'h8000, 32'h0};
        patterns[5] = $urandom_range(0, 65535);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset pattern.
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_UNUSED, -1, -1, -1, -1);
        send_word(OP_LOAD, -2048, 2047, -2048, 2047);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_LOAD, -2048, -2048, 2047, 2047);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_LOAD, 2047, -2048, -2048, 2047);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_LOAD, 0, 0, 2, -5);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_CLEAR, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_LOAD, 4, -2, 0, 0);
        repeat (6) send_word(OP_TICK, 0, 0, 0, 0);
        settle();
        apb_access(1'b0, 32'h0);

        for (int ph = 0; ph < 6; ph++) begin
            apb_access(1'b1, patterns[ph]);
            apb_access(1'b0, 32'h0);
            if (ph == 2)
                hold_request = 1;
            random_segments(SEG_WORDS);
            settle();
        end

        if (mismatches == 0)
            $display("tb_dashed_midpoint_line_rasterizer_unit passed");
        else
            $display("tb_dashed_midpoint_line_rasterizer_unit failed");
        $finish;
    end

endmodule
